@@ hw/rtl/bfcm_pkg.sv @@
// ----------------------------------------------------------------------------
// Buffer frame clock manager package
// Shared widths, function and status codes, and the queue entry type.
// ----------------------------------------------------------------------------
package bfcm_pkg;

  localparam int NumFrames  = 16;
  localparam int FrameW     = 6;
  localparam int IdxW       = (NumFrames > 1) ? $clog2(NumFrames) : 1;

  localparam logic [2:0] FUNC_READ    = 3'd0;
  localparam logic [2:0] FUNC_UNPIN   = 3'd1;
  localparam logic [2:0] FUNC_ALLOC   = 3'd2;
  localparam logic [2:0] FUNC_DISPOSE = 3'd3;
  localparam logic [2:0] FUNC_FLUSH   = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOFRAME   = 3'd1;
  localparam logic [2:0] ST_NOTFOUND  = 3'd2;
  localparam logic [2:0] ST_NOTPINNED = 3'd3;
  localparam logic [2:0] ST_PINNED    = 3'd4;
  localparam logic [2:0] ST_BADBUF    = 3'd5;

  // Command handed from the front end to the back end.
  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  file_id;
    logic [23:0] page_no;
    logic        mark_dirty;
  } cmd_t;

endpackage

@@ hw/rtl/bfcm_if.sv @@
// ----------------------------------------------------------------------------
// Buffer frame clock manager channels
// Valid/ready interfaces for request and result transactions.
// ----------------------------------------------------------------------------
interface bfcm_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [7:0]  file_id;
  logic [23:0] page_no;
  logic        mark_dirty;
  modport source (output valid, func, file_id, page_no, mark_dirty, input ready);
  modport sink   (input valid, func, file_id, page_no, mark_dirty, output ready);
endinterface

interface bfcm_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [5:0]  frame;
  logic        hit;
  logic        writeback;
  logic [7:0]  wb_file;
  logic [23:0] wb_page;
  logic        last;
  modport source (output valid, status, frame, hit, writeback, wb_file, wb_page, last,
                  input ready);
  modport sink   (input valid, status, frame, hit, writeback, wb_file, wb_page, last,
                  output ready);
endinterface

@@ hw/rtl/bfcm_front.sv @@
// ----------------------------------------------------------------------------
// Buffer frame clock manager front end
// Accepts request transactions into a two-entry command queue.
// ----------------------------------------------------------------------------
module bfcm_front (
  input  logic                clk,
  input  logic                rst,
  bfcm_req_if.sink            req,
  output logic                cmd_valid,
  output bfcm_pkg::cmd_t      cmd,
  input  logic                cmd_pop
);

  bfcm_pkg::cmd_t q [2];
  logic           rd_ptr;
  logic           wr_ptr;
  logic [1:0]     count;
  logic           push;

  assign req.ready = (count != 2'd2);
  assign push      = req.valid && req.ready;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{func: req.func, file_id: req.file_id, page_no: req.page_no,
                     mark_dirty: req.mark_dirty};
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (cmd_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, cmd_pop};
    end
  end

endmodule

@@ hw/rtl/bfcm_back.sv @@
// ----------------------------------------------------------------------------
// Buffer frame clock manager back end
// Frame table, associative lookup, clock sweep and flush walk.
// ----------------------------------------------------------------------------
module bfcm_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  bfcm_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  bfcm_rsp_if.source          rsp
);

  localparam int N  = bfcm_pkg::NumFrames;
  localparam int IW = bfcm_pkg::IdxW;
  localparam logic [IW-1:0] LastIdx = IW'(N - 1);

  typedef enum logic [2:0] {S_IDLE, S_LOOK, S_SWEEP, S_FLUSH, S_OUT} state_t;

  state_t        state;
  logic [N-1:0]  fvalid;
  logic [N-1:0]  refb;
  logic [N-1:0]  dirty;
  logic [7:0]    pin     [N];
  logic [7:0]    tfile   [N];
  logic [23:0]   tpage   [N];
  logic [IW-1:0] hand;
  logic [IW:0]   steps;
  logic          pass2;
  logic          cleared;
  logic [IW-1:0] fidx;
  logic          flush_done;
  bfcm_pkg::cmd_t cur;

  logic [N-1:0]  match;
  logic          found;
  logic [IW-1:0] found_idx;
  logic [IW-1:0] hand_nx;

  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = 0; i < N; i++) begin
      match[i] = fvalid[i] && tfile[i] == cur.file_id && tpage[i] == cur.page_no;
    end
    for (int i = N - 1; i >= 0; i--) begin
      if (match[i]) begin
        found     = 1'b1;
        found_idx = IW'(i);
      end
    end
    hand_nx = (hand == LastIdx) ? '0 : hand + 1'b1;
  end

  assign cmd_pop = (state == S_IDLE) && cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fvalid    <= '0;
      refb      <= '0;
      dirty     <= '0;
      for (int i = 0; i < N; i++) pin[i] <= '0;
      hand      <= LastIdx;
      rsp.valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur   <= cmd;
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          rsp.status    <= bfcm_pkg::ST_OK;
          rsp.frame     <= '0;
          rsp.hit       <= 1'b0;
          rsp.writeback <= 1'b0;
          rsp.wb_file   <= '0;
          rsp.wb_page   <= '0;
          rsp.last      <= 1'b1;
          state         <= S_OUT;
          case (cur.func)
            bfcm_pkg::FUNC_READ: begin
              if (found) begin
                if (pin[found_idx] != 8'd255) pin[found_idx] <= pin[found_idx] + 8'd1;
                refb[found_idx] <= 1'b1;
                rsp.frame       <= bfcm_pkg::FrameW'(found_idx);
                rsp.hit         <= 1'b1;
              end else begin
                steps   <= '0;
                pass2   <= 1'b0;
                cleared <= 1'b0;
                state   <= S_SWEEP;
              end
            end
            bfcm_pkg::FUNC_UNPIN: begin
              if (!found) begin
                rsp.status <= bfcm_pkg::ST_NOTFOUND;
              end else begin
                rsp.frame <= bfcm_pkg::FrameW'(found_idx);
                rsp.hit   <= 1'b1;
                if (pin[found_idx] == 8'd0) begin
                  rsp.status <= bfcm_pkg::ST_NOTPINNED;
                end else begin
                  pin[found_idx] <= pin[found_idx] - 8'd1;
                  if (cur.mark_dirty) dirty[found_idx] <= 1'b1;
                end
              end
            end
            bfcm_pkg::FUNC_ALLOC: begin
              if (found) begin
                rsp.status <= bfcm_pkg::ST_NOTFOUND;
                rsp.frame  <= bfcm_pkg::FrameW'(found_idx);
                rsp.hit    <= 1'b1;
              end else begin
                steps   <= '0;
                pass2   <= 1'b0;
                cleared <= 1'b0;
                state   <= S_SWEEP;
              end
            end
            bfcm_pkg::FUNC_DISPOSE: begin
              if (found) begin
                fvalid[found_idx] <= 1'b0;
                pin[found_idx]    <= '0;
                refb[found_idx]   <= 1'b0;
                dirty[found_idx]  <= 1'b0;
                rsp.frame         <= bfcm_pkg::FrameW'(found_idx);
                rsp.hit           <= 1'b1;
              end
            end
            bfcm_pkg::FUNC_FLUSH: begin
              fidx       <= '0;
              flush_done <= 1'b0;
              state      <= S_FLUSH;
            end
            default: rsp.status <= bfcm_pkg::ST_BADBUF;
          endcase
          if (cur.func != bfcm_pkg::FUNC_FLUSH && !(state == S_LOOK && !found &&
              (cur.func == bfcm_pkg::FUNC_READ || cur.func == bfcm_pkg::FUNC_ALLOC))) begin
            rsp.valid <= 1'b1;
          end
        end
        S_SWEEP: begin
          // One frame is examined per cycle; the hand moves before each look.
          hand <= hand_nx;
          if (!fvalid[hand_nx] || (pin[hand_nx] == 8'd0 && !refb[hand_nx])) begin
            if (fvalid[hand_nx] && dirty[hand_nx]) begin
              rsp.writeback <= 1'b1;
              rsp.wb_file   <= tfile[hand_nx];
              rsp.wb_page   <= tpage[hand_nx];
            end
            fvalid[hand_nx] <= 1'b1;
            pin[hand_nx]    <= 8'd1;
            refb[hand_nx]   <= 1'b1;
            dirty[hand_nx]  <= 1'b0;
            tfile[hand_nx]  <= cur.file_id;
            tpage[hand_nx]  <= cur.page_no;
            rsp.frame       <= bfcm_pkg::FrameW'(hand_nx);
            rsp.valid       <= 1'b1;
            state           <= S_OUT;
          end else begin
            if (pin[hand_nx] == 8'd0) begin
              refb[hand_nx] <= 1'b0;
            end
            if (steps == (IW+1)'(N - 1)) begin
              steps <= '0;
              if (!pass2 && (cleared || pin[hand_nx] == 8'd0)) begin
                pass2   <= 1'b1;
                cleared <= 1'b0;
              end else begin
                rsp.status <= bfcm_pkg::ST_NOFRAME;
                rsp.valid  <= 1'b1;
                state      <= S_OUT;
              end
            end else begin
              steps <= steps + 1'b1;
              if (pin[hand_nx] == 8'd0) cleared <= 1'b1;
            end
          end
        end
        S_FLUSH: begin
          // Walk frames in index order; only dirty frames, a pinned frame (which ends the walk) and the end report.
          if (!rsp.valid || rsp.ready) begin
            rsp.valid <= 1'b0;
            if (flush_done) begin
              rsp.status    <= bfcm_pkg::ST_OK;
              rsp.frame     <= '0;
              rsp.writeback <= 1'b0;
              rsp.wb_file   <= '0;
              rsp.wb_page   <= '0;
              rsp.last      <= 1'b1;
              rsp.valid     <= 1'b1;
              state         <= S_OUT;
            end else if (fvalid[fidx] && tfile[fidx] == cur.file_id) begin
              if (pin[fidx] != 8'd0) begin
                rsp.status    <= bfcm_pkg::ST_PINNED;
                rsp.frame     <= bfcm_pkg::FrameW'(fidx);
                rsp.writeback <= 1'b0;
                rsp.wb_file   <= '0;
                rsp.wb_page   <= '0;
                rsp.last      <= 1'b1;
                rsp.valid     <= 1'b1;
                state         <= S_OUT;
              end else begin
                if (dirty[fidx]) begin
                  rsp.status    <= bfcm_pkg::ST_OK;
                  rsp.frame     <= bfcm_pkg::FrameW'(fidx);
                  rsp.writeback <= 1'b1;
                  rsp.wb_file   <= tfile[fidx];
                  rsp.wb_page   <= tpage[fidx];
                  rsp.last      <= 1'b0;
                  rsp.valid     <= 1'b1;
                end
                fvalid[fidx] <= 1'b0;
                refb[fidx]   <= 1'b0;
                dirty[fidx]  <= 1'b0;
                if (fidx == LastIdx) flush_done <= 1'b1;
                else fidx <= fidx + 1'b1;
              end
            end else begin
              if (fidx == LastIdx) flush_done <= 1'b1;
              else fidx <= fidx + 1'b1;
            end
          end
        end
        S_OUT: begin
          if (rsp.ready) begin
            rsp.valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/buffer_frame_clock_manager_top.sv @@
// ----------------------------------------------------------------------------
// Buffer frame clock manager top level
// Buffer pool frame table with clock replacement.
// ----------------------------------------------------------------------------
// A request transaction is queued by the front end (two entries) and carried
// out one at a time by the back end. Hits, unpin, dispose and bad codes are
// taken in the idle state, looked up, and answered from the output state,
// where the registered result is held until the result handshake. A miss runs
// the clock sweep, one frame per cycle, for up to two passes over the frames.
// A flush walks the frames in index order, stops early at a pinned frame of
// its file, may wait on the result channel for each writeback it reports, and
// ends with a final result.
module buffer_frame_clock_manager_top (
  input  logic       clk,
  input  logic       rst,
  bfcm_req_if.sink   req,
  bfcm_rsp_if.source rsp
);

  logic           cmd_valid;
  logic           cmd_pop;
  bfcm_pkg::cmd_t cmd;

  bfcm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  bfcm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .rsp       (rsp)
  );

  // The back end takes a command only when the queue holds one.
  assert property (@(posedge clk) disable iff (rst) cmd_pop |-> cmd_valid)
    else $error("command popped from empty queue");

  // A writeback result never carries a non-ok status.
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.writeback |-> rsp.status == bfcm_pkg::ST_OK)
    else $error("writeback with error status");

  // A non-final result is always a flush writeback.
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.last |-> rsp.writeback)
    else $error("non-final result without writeback");

endmodule
